// ===== hw/rtl/sprite_atlas_shelf_packer_assert.svh =====
// Assertion macros used by the sprite atlas shelf packer checker.
`ifndef SPRITE_ATLAS_SHELF_PACKER_ASSERT_SVH
`define SPRITE_ATLAS_SHELF_PACKER_ASSERT_SVH

// Clocked on clk, disabled while rst_n is low, with a caller-given message.
`define SAP_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same, with a generic message.
`define SAP_ASSERT(lbl, prop) \
  `SAP_ASSERT_MSG(lbl, prop, "sprite atlas shelf packer check failed")

`endif

// ===== hw/rtl/sap_pkg.sv =====
// Types and constants of the sprite atlas shelf packer.
package sap_pkg;

  localparam int ATLAS_WIDTH  = 512;
  localparam int ATLAS_HEIGHT = 512;
  localparam int PAD          = 1;

  // cursor / extent widths follow the atlas size
  localparam int COL_W   = $clog2(ATLAS_WIDTH) + 1;
  localparam int ROW_W   = $clog2(ATLAS_HEIGHT) + 2;
  localparam int SHELF_W = $clog2(ATLAS_HEIGHT) + 1;
  localparam int EXTH_W  = $clog2(ATLAS_HEIGHT) + 1;

  // box coordinates and arithmetic on them
  localparam int BOX_W  = 17;
  localparam int CALC_W = 19;

  // result field widths
  localparam int POS_W = 9;
  localparam int EXT_W = 10;

  localparam logic signed [BOX_W-1:0] BOX_MIN_RESET = 17'sd32767;
  localparam logic signed [BOX_W-1:0] BOX_MAX_RESET = -17'sd32768;
  localparam logic signed [BOX_W-1:0] BOX_EDGE_MAX  = 17'sd32767;

  localparam logic [7:0] PART_SIZE_MAX = 8'd64;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 128;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_PART  = 2'd1,
    ACT_PLACE = 2'd2
  } action_t;

  typedef enum logic {
    REG_CAMERA_X = 1'b0,
    REG_CAMERA_Y = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic bad;
    logic has_parts;
  } obj_flags_t;

  // first member is the top bits
  typedef struct packed {
    logic [5:0]         pad;
    logic               raster_ok;
    logic [15:0]        world_y;
    logic [15:0]        world_x;
    logic               part_reserved;
    logic [7:0]         part_size;
    logic signed [15:0] part_y;
    logic signed [15:0] part_x;
  } in_data_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic [EXT_W-1:0]   dirty_height;
    logic [EXT_W-1:0]   dirty_width;
    logic [EXT_W-1:0]   reach_height;
    logic [EXT_W-1:0]   reach_width;
    logic signed [15:0] local_bottom;
    logic signed [15:0] local_right;
    logic signed [15:0] local_top;
    logic signed [15:0] local_left;
    logic [POS_W-1:0]   atlas_y;
    logic [POS_W-1:0]   atlas_x;
  } out_data_t;

endpackage

// ===== hw/rtl/sprite_atlas_shelf_packer.sv =====
// Sprite atlas shelf packer: next-fit shelf placement of object bounding boxes.
// Each request is handled in the cycle it is accepted: start-frame and part
// requests update the cursors, extents and object box directly, and a place
// request loads the output register, which presents its result from the next
// cycle on. A new request is taken every cycle (one request per cycle
// sustained); in_tready drops only while a result sits in the output register
// and out_tready is low. There is no memory and no clearing pass after reset.
module sprite_atlas_shelf_packer
  import sap_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // part_x, part_y, part_size, part_reserved, world_x, world_y, raster_ok, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic [1:0]            in_tuser,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // atlas_x, atlas_y, local_left, local_top, local_right, local_bottom,
  // reach_width, reach_height, dirty_width, dirty_height, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // placed
  output logic [0:0]            out_tuser,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [15:0] cam_x_r, cam_y_r;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [SHELF_W-1:0] shelf_r, shelf_nxt;
  logic [COL_W-1:0]   used_w_r, used_w_nxt, dirty_w_r, dirty_w_nxt;
  logic [EXTH_W-1:0]  used_h_r, used_h_nxt, dirty_h_r, dirty_h_nxt;
  logic signed [BOX_W-1:0] min_x_r, min_x_nxt, min_y_r, min_y_nxt;
  logic signed [BOX_W-1:0] max_x_r, max_x_nxt, max_y_r, max_y_nxt;
  obj_flags_t flags_r, flags_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_data_t out_data_r, out_data_nxt;
  logic      placed_r, placed_nxt;

  in_data_t  din;
  action_t   act;
  logic      accept, cfg_wr;

  logic                    size_bad;
  logic signed [BOX_W-1:0] px, py, pex, pey;
  logic                    box_ok, size_ok, wrap, fit;
  logic [CALC_W-1:0]       w, h, col_c, row_c, shelf_c, col_eff, row_eff, shelf_eff;
  logic [CALC_W-1:0]       col_end, row_end;
  logic signed [BOX_W:0]   w_full, h_full;
  logic [15:0]             cam_rel_x, cam_rel_y;

  assign din    = in_data_t'(in_tdata);
  assign act    = action_t'(in_tuser);
  assign accept = in_tvalid && in_tready;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign in_tready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);
  assign out_tuser  = placed_r;

  assign cfg_pready = 1'b1;
  always_comb begin
    case (reg_idx_t'(cfg_paddr[2]))
      REG_CAMERA_X: cfg_prdata = {16'd0, cam_x_r};
      REG_CAMERA_Y: cfg_prdata = {16'd0, cam_y_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // part folding
  assign size_bad = din.part_reserved || (din.part_size == 8'd0) ||
                    (din.part_size > PART_SIZE_MAX) || (din.part_size[2:0] != 3'd0);
  assign px  = BOX_W'(din.part_x);
  assign py  = BOX_W'(din.part_y);
  assign pex = px + $signed(BOX_W'(din.part_size));
  assign pey = py + $signed(BOX_W'(din.part_size));

  // placement
  assign box_ok = flags_r.has_parts && !flags_r.bad &&
                  (max_x_r > min_x_r) && (max_y_r > min_y_r) &&
                  (max_x_r <= BOX_EDGE_MAX) && (max_y_r <= BOX_EDGE_MAX);
  assign w_full = (BOX_W+1)'(max_x_r) - (BOX_W+1)'(min_x_r);
  assign h_full = (BOX_W+1)'(max_y_r) - (BOX_W+1)'(min_y_r);
  assign w = box_ok ? CALC_W'(w_full[BOX_W-1:0]) : '0;
  assign h = box_ok ? CALC_W'(h_full[BOX_W-1:0]) : '0;

  assign col_c   = CALC_W'(col_r);
  assign row_c   = CALC_W'(row_r);
  assign shelf_c = CALC_W'(shelf_r);

  assign size_ok = box_ok && (w + CALC_W'(2*PAD) <= CALC_W'(ATLAS_WIDTH)) &&
                   (h + CALC_W'(2*PAD) <= CALC_W'(ATLAS_HEIGHT));
  assign wrap    = size_ok && (col_c + w + CALC_W'(PAD) > CALC_W'(ATLAS_WIDTH));
  assign col_eff   = wrap ? CALC_W'(PAD) : col_c;
  assign row_eff   = wrap ? row_c + shelf_c + CALC_W'(PAD) : row_c;
  assign shelf_eff = wrap ? '0 : shelf_c;
  assign fit     = size_ok && (row_eff + h + CALC_W'(PAD) <= CALC_W'(ATLAS_HEIGHT));
  assign col_end = col_eff + w;
  assign row_end = row_eff + h;

  assign cam_rel_x = din.world_x - cam_x_r;
  assign cam_rel_y = din.world_y - cam_y_r;

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    shelf_nxt   = shelf_r;
    used_w_nxt  = used_w_r;
    used_h_nxt  = used_h_r;
    dirty_w_nxt = dirty_w_r;
    dirty_h_nxt = dirty_h_r;
    min_x_nxt   = min_x_r;
    min_y_nxt   = min_y_r;
    max_x_nxt   = max_x_r;
    max_y_nxt   = max_y_r;
    flags_nxt   = flags_r;
    out_data_nxt  = out_data_r;
    placed_nxt    = placed_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (accept) begin
      case (act)
        ACT_START: begin
          col_nxt     = COL_W'(PAD);
          row_nxt     = ROW_W'(PAD);
          shelf_nxt   = '0;
          used_w_nxt  = '0;
          used_h_nxt  = '0;
          dirty_w_nxt = '0;
          dirty_h_nxt = '0;
          min_x_nxt   = BOX_MIN_RESET;
          min_y_nxt   = BOX_MIN_RESET;
          max_x_nxt   = BOX_MAX_RESET;
          max_y_nxt   = BOX_MAX_RESET;
          flags_nxt   = '0;
        end
        ACT_PART: begin
          if (size_bad) begin
            flags_nxt.bad = 1'b1;
          end else if (!flags_r.bad) begin
            flags_nxt.has_parts = 1'b1;
            if (px < min_x_r) min_x_nxt = px;
            if (py < min_y_r) min_y_nxt = py;
            if (pex > max_x_r) max_x_nxt = pex;
            if (pey > max_y_r) max_y_nxt = pey;
          end
        end
        ACT_PLACE: begin
          logic [CALC_W-1:0] uw, uh, dw, dh;
          uw = CALC_W'(used_w_r);
          uh = CALC_W'(used_h_r);
          dw = CALC_W'(dirty_w_r);
          dh = CALC_W'(dirty_h_r);
          out_valid_nxt = 1'b1;
          placed_nxt    = 1'b0;
          out_data_nxt  = '0;
          if (size_ok) begin
            col_nxt   = COL_W'(col_eff);
            row_nxt   = ROW_W'(row_eff);
            shelf_nxt = SHELF_W'(shelf_eff);
          end
          if (fit) begin
            if (col_end > dw) dw = col_end;
            if (row_end > dh) dh = row_end;
            if (din.raster_ok) begin
              placed_nxt = 1'b1;
              out_data_nxt.atlas_x      = col_eff[POS_W-1:0];
              out_data_nxt.atlas_y      = row_eff[POS_W-1:0];
              out_data_nxt.local_left   = min_x_r[15:0] - cam_rel_x;
              out_data_nxt.local_top    = min_y_r[15:0] - cam_rel_y;
              out_data_nxt.local_right  = max_x_r[15:0] - cam_rel_x;
              out_data_nxt.local_bottom = max_y_r[15:0] - cam_rel_y;
              if (col_end > uw) uw = col_end;
              if (row_end > uh) uh = row_end;
              if (h > shelf_eff) shelf_nxt = SHELF_W'(h);
              col_nxt = COL_W'(col_end + CALC_W'(PAD));
            end
          end
          used_w_nxt  = COL_W'(uw);
          used_h_nxt  = EXTH_W'(uh);
          dirty_w_nxt = COL_W'(dw);
          dirty_h_nxt = EXTH_W'(dh);
          // extents reported modulo 2^10
          out_data_nxt.reach_width  = uw[EXT_W-1:0];
          out_data_nxt.reach_height = uh[EXT_W-1:0];
          out_data_nxt.dirty_width  = dw[EXT_W-1:0];
          out_data_nxt.dirty_height = dh[EXT_W-1:0];
          // object done, next one starts empty
          min_x_nxt = BOX_MIN_RESET;
          min_y_nxt = BOX_MIN_RESET;
          max_x_nxt = BOX_MAX_RESET;
          max_y_nxt = BOX_MAX_RESET;
          flags_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r     <= '0;
      cam_y_r     <= '0;
      col_r       <= COL_W'(PAD);
      row_r       <= ROW_W'(PAD);
      shelf_r     <= '0;
      used_w_r    <= '0;
      used_h_r    <= '0;
      dirty_w_r   <= '0;
      dirty_h_r   <= '0;
      min_x_r     <= BOX_MIN_RESET;
      min_y_r     <= BOX_MIN_RESET;
      max_x_r     <= BOX_MAX_RESET;
      max_y_r     <= BOX_MAX_RESET;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_t'(cfg_paddr[2]))
          REG_CAMERA_X: cam_x_r <= cfg_pwdata[15:0];
          REG_CAMERA_Y: cam_y_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      shelf_r     <= shelf_nxt;
      used_w_r    <= used_w_nxt;
      used_h_r    <= used_h_nxt;
      dirty_w_r   <= dirty_w_nxt;
      dirty_h_r   <= dirty_h_nxt;
      min_x_r     <= min_x_nxt;
      min_y_r     <= min_y_nxt;
      max_x_r     <= max_x_nxt;
      max_y_r     <= max_y_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    placed_r   <= placed_nxt;
  end

endmodule

// ===== hw/rtl/sap_checker.sv =====
// Port-level checker for the sprite atlas shelf packer, with its bind.
`include "sprite_atlas_shelf_packer_assert.svh"

module sap_checker
  import sap_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [1:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]            out_tuser
);

  out_data_t od;
  logic      place_req, other_req;
  logic      purge_clean, ext_order_ok;

  assign od        = out_data_t'(out_tdata);
  assign place_req = in_tvalid && in_tready && (action_t'(in_tuser) == ACT_PLACE);
  assign other_req = in_tvalid && in_tready && (action_t'(in_tuser) != ACT_PLACE);

  assign purge_clean = (od.atlas_x == '0) && (od.atlas_y == '0) &&
                       (od.local_left == '0) && (od.local_top == '0) &&
                       (od.local_right == '0) && (od.local_bottom == '0);
  assign ext_order_ok = (od.reach_width <= od.dirty_width) &&
                        (od.reach_height <= od.dirty_height);

  // a stalled result holds
  `SAP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // a purged object reports no placement or local bounds
  `SAP_ASSERT_MSG(a_purge_zero, out_tvalid && !out_tuser[0] |-> purge_clean, "purged result carries placement data")

  // used extents never pass dirty extents
  `SAP_ASSERT(a_used_le_dirty, out_tvalid |-> ext_order_ok)

  // each place request gives a result the next cycle, other requests give none
  `SAP_ASSERT(a_place_result, place_req |=> out_tvalid)
  `SAP_ASSERT(a_no_spurious, other_req && (!out_tvalid || out_tready) |=> !out_tvalid)

endmodule

bind sprite_atlas_shelf_packer sap_checker u_sap_checker (.*);

// ===== tb/sprite_atlas_shelf_packer_tb.sv =====
// Self-checking testbench of the sprite atlas shelf packer: directed table, then random frames.
module sprite_atlas_shelf_packer_tb;
  import sap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_NONE = 2'd3;  // not decoded by the block
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic      placed;
    out_data_t d;
  } placement_t;

  typedef struct {
    logic [1:0] act;
    in_data_t   d;
    bit         typed;
    placement_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  sprite_atlas_shelf_packer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  // packer state as seen by the predictor
  logic [15:0] cam_x, cam_y;
  int          cur_col, cur_row, shelf_h;
  int          used_w, used_h, dirty_w, dirty_h;
  int          bmin_x, bmin_y, bmax_x, bmax_y;
  bit          obj_has_parts, obj_bad;

  placement_t  placed_q[$];
  int          mismatches = 0;
  int          sent_items = 0;
  int          tx_idle = 0;
  int          rx_idle = 0;
  bit          cur_typed = 1'b0;
  placement_t  cur_want = '0;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int          hold_left = 0;
  int          quiet = 0;

  function automatic void clear_box();
    bmin_x = BOX_MIN_RESET;
    bmin_y = BOX_MIN_RESET;
    bmax_x = BOX_MAX_RESET;
    bmax_y = BOX_MAX_RESET;
    obj_has_parts = 1'b0;
    obj_bad = 1'b0;
  endfunction

  function automatic void clear_frame();
    cur_col = PAD;
    cur_row = PAD;
    shelf_h = 0;
    used_w = 0;
    used_h = 0;
    dirty_w = 0;
    dirty_h = 0;
    clear_box();
  endfunction

  // next-fit shelf packing of one request; has_res is set for place requests only
  function automatic void shelf_step(input logic [1:0] act, input in_data_t d,
                                     output bit has_res, output placement_t res);
    int sz, px, py, w, h, ax, ay;
    bit ok;
    logic signed [15:0] ax16, ay16;
    has_res = 1'b0;
    res = '0;
    case (act)
      ACT_START: clear_frame();
      ACT_PART: begin
        sz = d.part_size;
        if (d.part_reserved || sz == 0 || sz > PART_SIZE_MAX || sz[2:0] != 0) begin
          obj_bad = 1'b1;
        end else if (!obj_bad) begin
          obj_has_parts = 1'b1;
          px = $signed(d.part_x);
          py = $signed(d.part_y);
          if (px < bmin_x) bmin_x = px;
          if (py < bmin_y) bmin_y = py;
          if (px + sz > bmax_x) bmax_x = px + sz;
          if (py + sz > bmax_y) bmax_y = py + sz;
        end
      end
      ACT_PLACE: begin
        has_res = 1'b1;
        ok = obj_has_parts && !obj_bad;
        w = 0;
        h = 0;
        if (ok && (bmax_x <= bmin_x || bmax_y <= bmin_y ||
                   bmax_x > BOX_EDGE_MAX || bmax_y > BOX_EDGE_MAX))
          ok = 1'b0;
        if (ok) begin
          w = bmax_x - bmin_x;
          h = bmax_y - bmin_y;
          if (w + 2 * PAD > ATLAS_WIDTH || h + 2 * PAD > ATLAS_HEIGHT) ok = 1'b0;
        end
        if (ok) begin
          // wrap is kept even when the box then does not fit below
          if (cur_col + w + PAD > ATLAS_WIDTH) begin
            cur_col = PAD;
            cur_row += shelf_h + PAD;
            shelf_h = 0;
          end
          if (cur_row + h + PAD > ATLAS_HEIGHT) ok = 1'b0;
        end
        if (ok) begin
          if (cur_col + w > dirty_w) dirty_w = cur_col + w;
          if (cur_row + h > dirty_h) dirty_h = cur_row + h;
          if (d.raster_ok) begin
            ax16 = d.world_x - cam_x;
            ay16 = d.world_y - cam_y;
            ax = ax16;
            ay = ay16;
            res.placed = 1'b1;
            res.d.atlas_x = POS_W'(cur_col);
            res.d.atlas_y = POS_W'(cur_row);
            res.d.local_left = 16'(bmin_x - ax);
            res.d.local_top = 16'(bmin_y - ay);
            res.d.local_right = 16'(bmax_x - ax);
            res.d.local_bottom = 16'(bmax_y - ay);
            if (cur_col + w > used_w) used_w = cur_col + w;
            if (cur_row + h > used_h) used_h = cur_row + h;
            if (h > shelf_h) shelf_h = h;
            cur_col += w + PAD;
          end
        end
        res.d.reach_width = EXT_W'(used_w);
        res.d.reach_height = EXT_W'(used_h);
        res.d.dirty_width = EXT_W'(dirty_w);
        res.d.dirty_height = EXT_W'(dirty_h);
        clear_box();
      end
      default: ;
    endcase
  endfunction

  function automatic void cmp_field(string name, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
    end
  endfunction

  function automatic void check_placement(placement_t e, placement_t a);
    cmp_field("placed", 16'(e.placed), 16'(a.placed));
    cmp_field("atlas_x", 16'(e.d.atlas_x), 16'(a.d.atlas_x));
    cmp_field("atlas_y", 16'(e.d.atlas_y), 16'(a.d.atlas_y));
    cmp_field("local_left", e.d.local_left, a.d.local_left);
    cmp_field("local_top", e.d.local_top, a.d.local_top);
    cmp_field("local_right", e.d.local_right, a.d.local_right);
    cmp_field("local_bottom", e.d.local_bottom, a.d.local_bottom);
    cmp_field("reach_width", 16'(e.d.reach_width), 16'(a.d.reach_width));
    cmp_field("reach_height", 16'(e.d.reach_height), 16'(a.d.reach_height));
    cmp_field("dirty_width", 16'(e.d.dirty_width), 16'(a.d.dirty_width));
    cmp_field("dirty_height", 16'(e.d.dirty_height), 16'(a.d.dirty_height));
  endfunction

  // monitor: results checked first, since they belong to older requests
  always @(posedge clk) begin : mon
    placement_t got, calc;
    bit has;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.placed = out_tuser[0];
        got.d = out_tdata;
        if (placed_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got placed=%0b data=%h",
                   $time, got.placed, out_tdata);
        end else begin
          check_placement(placed_q.pop_front(), got);
        end
      end
      if (in_tvalid && in_tready) begin
        shelf_step(in_tuser, in_tdata, has, calc);
        if (has) placed_q.push_back(cur_typed ? cur_want : calc);
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == CFG_ADDR_W'(4 * int'(REG_CAMERA_X))) cam_x = cfg_pwdata[15:0];
        else if (cfg_paddr == CFG_ADDR_W'(4 * int'(REG_CAMERA_Y))) cam_y = cfg_pwdata[15:0];
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("sprite_atlas_shelf_packer_tb NOT OK");
      $finish;
    end
  end

  // result side backpressure; a long hold is requested by toggling hold_req
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(99) >= rx_idle);
    end
  end

  function automatic in_data_t part_req(logic [15:0] x, logic [15:0] y, logic [7:0] sz,
                                        logic rsv);
    in_data_t d;
    d = '0;
    d.part_x = x;
    d.part_y = y;
    d.part_size = sz;
    d.part_reserved = rsv;
    return d;
  endfunction

  function automatic in_data_t place_req(logic [15:0] wx, logic [15:0] wy, logic rok);
    in_data_t d;
    d = '0;
    d.world_x = wx;
    d.world_y = wy;
    d.raster_ok = rok;
    return d;
  endfunction

  function automatic placement_t mk_result(logic p, int ax, int ay, logic [15:0] ll,
                                           logic [15:0] lt, logic [15:0] lr,
                                           logic [15:0] lb, int uw, int uh, int dw, int dh);
    placement_t r;
    r = '0;
    r.placed = p;
    r.d.atlas_x = POS_W'(ax);
    r.d.atlas_y = POS_W'(ay);
    r.d.local_left = ll;
    r.d.local_top = lt;
    r.d.local_right = lr;
    r.d.local_bottom = lb;
    r.d.reach_width = EXT_W'(uw);
    r.d.reach_height = EXT_W'(uh);
    r.d.dirty_width = EXT_W'(dw);
    r.d.dirty_height = EXT_W'(dh);
    return r;
  endfunction

  task automatic send_req(logic [1:0] act, in_data_t d, bit typed, placement_t want);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser = act;
    in_tdata = d;
    cur_typed = typed;
    cur_want = want;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    if (act != ACT_NONE) sent_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (placed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_camera(reg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = CFG_ADDR_W'(4 * int'(idx));
    cfg_pwdata = {16'h0, value};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // one object: up to four parts around a common base, then the place request
  task automatic send_object();
    int nparts, spread;
    logic [15:0] bx, by;
    logic [7:0] sz;
    nparts = ($urandom_range(99) < 4) ? 0 : $urandom_range(1, 4);
    case ($urandom_range(3))
      0: spread = 0;
      1: spread = 48;
      2: spread = 160;
      default: spread = 480;
    endcase
    bx = ($urandom_range(9) == 0) ? 16'(32767 - $urandom_range(600)) : 16'($urandom);
    by = ($urandom_range(9) == 0) ? 16'(32767 - $urandom_range(600)) : 16'($urandom);
    for (int i = 0; i < nparts; i++) begin
      sz = ($urandom_range(99) < 88) ? 8'(8 * $urandom_range(1, 8)) : 8'($urandom);
      send_req(ACT_PART, part_req(16'(bx + $urandom_range(spread)),
                                  16'(by + $urandom_range(spread)), sz,
                                  $urandom_range(99) < 3), 1'b0, '0);
    end
    send_req(ACT_PLACE, place_req(16'($urandom), 16'($urandom), $urandom_range(99) < 85),
             1'b0, '0);
  endtask

  task automatic run_random(int target);
    int r;
    in_data_t d;
    while (sent_items < target) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_req(ACT_START, in_data_t'(0), 1'b0, '0);
      end else if (r < 10) begin
        d = 80'({$urandom, $urandom, $urandom});
        d.pad = '0;
        send_req(2'($urandom_range(3)), d, 1'b0, '0);
      end else begin
        send_object();
      end
    end
  endtask

  initial begin
    stim_row_t rows[$];
    in_data_t all_ones;
    placement_t z65;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_START;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cam_x = '0;
    cam_y = '0;
    clear_frame();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_camera(REG_CAMERA_X, 16'h0000);
    write_camera(REG_CAMERA_Y, 16'h0000);

    all_ones = '1;
    all_ones.pad = '0;
    z65 = mk_result(0, 0, 0, 16'h0, 16'h0, 16'h0, 16'h0, 65, 65, 65, 65);
    // empty object right after reset
    rows.push_back('{ACT_PLACE, place_req(0, 0, 1), 1'b1, '0});
    rows.push_back('{ACT_PART, part_req(0, 0, 8'd0, 0), 1'b0, '0});
    rows.push_back('{ACT_PLACE, place_req(0, 0, 1), 1'b1, '0});
    // most negative corner, largest part
    rows.push_back('{ACT_PART, part_req(16'h8000, 16'h8000, 8'd64, 0), 1'b0, '0});
    rows.push_back('{ACT_PLACE, place_req(0, 0, 1), 1'b1,
                     mk_result(1, 1, 1, 16'h8000, 16'h8000, 16'h8040, 16'h8040,
                               65, 65, 65, 65)});
    // reserved part spoils the object
    rows.push_back('{ACT_PART, part_req(0, 0, 8'd8, 1), 1'b0, '0});
    rows.push_back('{ACT_PART, part_req(0, 0, 8'd8, 0), 1'b0, '0});
    rows.push_back('{ACT_PLACE, place_req(0, 0, 1), 1'b1, z65});
    // right edge past the box limit
    rows.push_back('{ACT_PART, part_req(16'h7FFF, 0, 8'd8, 0), 1'b0, '0});
    rows.push_back('{ACT_PLACE, place_req(0, 0, 1), 1'b1, z65});
    rows.push_back('{ACT_PART, part_req(0, 0, 8'd72, 0), 1'b0, '0});
    rows.push_back('{ACT_PLACE, place_req(0, 0, 1), 1'b1, z65});
    rows.push_back('{ACT_PART, part_req(0, 0, 8'd12, 0), 1'b0, '0});
    rows.push_back('{ACT_PART, part_req(0, 0, 8'd255, 1), 1'b0, '0});
    rows.push_back('{ACT_PLACE, place_req(0, 0, 1), 1'b1, z65});
    // 512 wide: no room for padding
    rows.push_back('{ACT_PART, part_req(0, 0, 8'd64, 0), 1'b0, '0});
    rows.push_back('{ACT_PART, part_req(16'd448, 0, 8'd64, 0), 1'b0, '0});
    rows.push_back('{ACT_PLACE, place_req(0, 0, 1), 1'b1, z65});
    rows.push_back('{ACT_NONE, all_ones, 1'b0, '0});
    // failed raster only grows the dirty extent
    rows.push_back('{ACT_PART, part_req(16'd100, 16'd100, 8'd40, 0), 1'b0, '0});
    rows.push_back('{ACT_PLACE, place_req(16'hFFFF, 16'hFFFF, 0), 1'b0, '0});
    rows.push_back('{ACT_PART, part_req(-16'sd5, 16'd7, 8'd8, 0), 1'b0, '0});
    rows.push_back('{ACT_PLACE, place_req(16'hFFFF, 16'hFFFF, 1), 1'b0, '0});
    rows.push_back('{ACT_START, in_data_t'(0), 1'b0, '0});
    rows.push_back('{ACT_PART, part_req(0, 0, 8'd8, 0), 1'b0, '0});
    rows.push_back('{ACT_PLACE, place_req(0, 0, 1), 1'b1,
                     mk_result(1, 1, 1, 16'h0, 16'h0, 16'h8, 16'h8, 9, 9, 9, 9)});
    foreach (rows[i]) send_req(rows[i].act, rows[i].d, rows[i].typed, rows[i].want);
    wait_drained();

    write_camera(REG_CAMERA_X, 16'hFFFF);
    write_camera(REG_CAMERA_Y, 16'($urandom));
    tx_idle = 24;
    rx_idle = 85;
    run_random(150);
    wait_drained();

    write_camera(REG_CAMERA_X, 16'($urandom));
    write_camera(REG_CAMERA_Y, 16'hFFFF);
    tx_idle = 85;
    rx_idle = 24;
    run_random(275);
    wait_drained();

    write_camera(REG_CAMERA_X, 16'h8000);
    write_camera(REG_CAMERA_Y, 16'h0001);
    tx_idle = 0;
    rx_idle = 0;
    hold_req = ~hold_req;  // long receiver hold while requests keep coming
    run_random(340);
    wait_drained();        // sender pauses until every result is out
    run_random(420);
    wait_drained();

    if (mismatches == 0) begin
      $display("sprite_atlas_shelf_packer_tb OK");
    end else begin
      $display("sprite_atlas_shelf_packer_tb NOT OK");
    end
    $finish;
  end

endmodule
